// File: rtl/overlay_window_setup_calc_top_macros.svh
// ----------------------------------------------------------------------------
// Overlay window setup calculator - assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef OVERLAY_WINDOW_SETUP_CALC_TOP_MACROS_SVH
`define OVERLAY_WINDOW_SETUP_CALC_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define OWSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define OWSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/owsc_pkg.sv
// ----------------------------------------------------------------------------
// owsc_pkg
// Widths, constants and types shared by the overlay window setup calculator.
// ----------------------------------------------------------------------------
package owsc_pkg;

	// Field widths
	localparam int FMT_W     = 2;
	localparam int KEY_W     = 24;
	localparam int COORD_W   = 12;
	localparam int SRC_W     = 11;
	localparam int POS_W     = 16;
	localparam int HZ_W      = 14;
	localparam int VZ_W      = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 8;

	// Divider geometry: the quotient is below 1024 because src < drawn size
	localparam int QUO_W     = 10;
	localparam int DVS_W     = 13;
	localparam int REM_W     = 13;
	localparam int DIFF_W    = 14;
	localparam int DIV_BITS_PER_STAGE = 2;

	// Overlay formats
	localparam logic [FMT_W-1:0] OVL_YUV422 = 2'd0;
	localparam logic [FMT_W-1:0] OVL_RGB565 = 2'd1;

	// Desktop formats
	localparam logic [1:0] DESK_PAL8   = 2'd0;
	localparam logic [1:0] DESK_RGB555 = 2'd1;
	localparam logic [1:0] DESK_RGB565 = 2'd2;
	localparam logic [1:0] DESK_TRUE   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DESKTOP_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_H_TOTAL        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H_SYNC_START   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_H_EXT_OVERFLOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_V_TOTAL        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_V_OVERFLOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_V_SYNC_START   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_V_EXT_OVERFLOW = 3'd7;

	// Timing offsets
	localparam logic [POS_W-1:0] H_TOTAL_ADJ = 16'd40;
	localparam logic [POS_W-1:0] H_SKEW_ADJ  = 16'd24;
	localparam logic [POS_W-1:0] V_TOTAL_ADJ = 16'd2;
	localparam logic [POS_W-1:0] V_SKEW_ADJ  = 16'd7;
	localparam logic [POS_W-1:0] X_START_ADJ = 16'd1;
	localparam logic [POS_W-1:0] X_END_ADJ   = 16'd4;
	localparam logic [POS_W-1:0] Y_END_ADJ   = 16'd5;
	localparam logic [DIFF_W-1:0] W_EXTRA    = 14'd6;
	localparam logic [DIFF_W-1:0] H_EXTRA    = 14'd2;

	// Key masks
	localparam logic [KEY_W-1:0] MASK_8  = 24'h0000ff;
	localparam logic [KEY_W-1:0] MASK_16 = 24'h00ffff;
	localparam logic [KEY_W-1:0] MASK_24 = 24'hffffff;

	// Zoom constants
	localparam logic [HZ_W-1:0] H_ZOOM_UNITY = 14'd1024;
	localparam logic [VZ_W-1:0] V_ZOOM_UNITY = 15'h03ff;
	localparam logic [VZ_W-1:0] V_ZOOM_FLAG  = 15'h4000;

	// Per-item results that ride alongside the dividers
	typedef struct packed {
		logic             format_error;
		logic             rgb_overlay;
		logic [KEY_W-1:0] key_value;
		logic [KEY_W-1:0] key_mask;
		logic [POS_W-1:0] win_x_start;
		logic [POS_W-1:0] win_x_end;
		logic [POS_W-1:0] win_y_start;
		logic [POS_W-1:0] win_y_end;
		logic             h_div;
		logic             v_div;
	} side_t;

endpackage

// File: rtl/owsc_div_pipe.sv
// ----------------------------------------------------------------------------
// owsc_div_pipe
// Pipelined restoring divider for the zoom factors, a few quotient bits per
// stage. The dividend is the remainder seed shifted up by QUO_W zero bits.
// ----------------------------------------------------------------------------
module owsc_div_pipe #(
	parameter int BITS_PER_STAGE = owsc_pkg::DIV_BITS_PER_STAGE,
	parameter int STAGES = (owsc_pkg::QUO_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE
) (
	input  logic                         clk,
	input  logic [STAGES-1:0]            adv,
	input  logic [owsc_pkg::DVS_W-1:0]   dvs_in,
	input  logic [owsc_pkg::REM_W-1:0]   rem_in,
	output logic [owsc_pkg::QUO_W-1:0]   quo
);

	localparam int QW = owsc_pkg::QUO_W;
	localparam int RW = owsc_pkg::REM_W;
	localparam int DW = owsc_pkg::DVS_W;

	logic [RW-1:0] rem_s [STAGES];
	logic [DW-1:0] dvs_s [STAGES];
	logic [QW-1:0] quo_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [RW-1:0] rem_prev;
		logic [DW-1:0] dvs_prev;
		logic [QW-1:0] quo_prev;
		logic [RW-1:0] rem_nxt;
		logic [QW-1:0] quo_nxt;

		if (k == 0) begin : g_first
			assign rem_prev = rem_in;
			assign dvs_prev = dvs_in;
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign dvs_prev = dvs_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		// shift-compare-subtract, one quotient bit per step
		always_comb begin
			logic [RW:0] trial;
			rem_nxt = rem_prev;
			quo_nxt = quo_prev;
			trial   = '0;
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				if (k * BITS_PER_STAGE + j < QW) begin
					trial = {rem_nxt, 1'b0};
					if (trial >= {1'b0, dvs_prev}) begin
						trial   = trial - {1'b0, dvs_prev};
						quo_nxt = {quo_nxt[QW-2:0], 1'b1};
					end else begin
						quo_nxt = {quo_nxt[QW-2:0], 1'b0};
					end
					rem_nxt = trial[RW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k] <= rem_nxt;
				dvs_s[k] <= dvs_prev;
				quo_s[k] <= quo_nxt;
			end
		end
	end

	assign quo = quo_s[STAGES-1];

endmodule

// File: rtl/overlay_window_setup_calc_top.sv
// ----------------------------------------------------------------------------
// overlay_window_setup_calc_top
// Overlay register calculator: key colour packing, window skew and zoom.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on in_valid/in_ready, one transfer per item; each gives
//    exactly one result on out_valid/out_ready.
//  - Configuration (desktop format and CRTC timing bytes) is written through
//    cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write it only
//    while no request is in flight.
//  - The pipeline is one preparation stage, the divider stages and one output
//    register. The depth is set by the 10-bit restoring division for the
//    zoom factors.
//  - One item per cycle while not stalled; every stage holds its own item.
//  - When out_ready is low the output register holds and the stall ripples
//    back stage by stage; in_ready falls only once every stage is full.
//  - Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module overlay_window_setup_calc_top #(
	parameter int DIV_BITS_PER_STAGE = owsc_pkg::DIV_BITS_PER_STAGE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [owsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owsc_pkg::CFG_W-1:0]        cfg_data,
	// requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [owsc_pkg::FMT_W-1:0]        overlay_format,
	input  logic [owsc_pkg::KEY_W-1:0]        key_color,
	input  logic [owsc_pkg::COORD_W-1:0]      dst_left,
	input  logic [owsc_pkg::COORD_W-1:0]      dst_right,
	input  logic [owsc_pkg::COORD_W-1:0]      dst_top,
	input  logic [owsc_pkg::COORD_W-1:0]      dst_bottom,
	input  logic [owsc_pkg::SRC_W-1:0]        src_width,
	input  logic [owsc_pkg::SRC_W-1:0]        src_height,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              format_error,
	output logic                              rgb_overlay,
	output logic [owsc_pkg::KEY_W-1:0]        key_value,
	output logic [owsc_pkg::KEY_W-1:0]        key_mask,
	output logic [owsc_pkg::POS_W-1:0]        win_x_start,
	output logic [owsc_pkg::POS_W-1:0]        win_x_end,
	output logic [owsc_pkg::POS_W-1:0]        win_y_start,
	output logic [owsc_pkg::POS_W-1:0]        win_y_end,
	output logic [owsc_pkg::HZ_W-1:0]         h_zoom,
	output logic [owsc_pkg::VZ_W-1:0]         v_zoom
);

	localparam int DIV_STAGES =
		(owsc_pkg::QUO_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam int NSTG = DIV_STAGES + 2;
	localparam int POS_W = owsc_pkg::POS_W;

	// ---------------- configuration registers ----------------
	logic [1:0]                  desktop_format_q;
	logic [owsc_pkg::CFG_W-1:0]  h_total_q, h_sync_start_q, h_ext_overflow_q;
	logic [owsc_pkg::CFG_W-1:0]  v_total_q, v_overflow_q, v_sync_start_q, v_ext_overflow_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desktop_format_q <= '0;
			h_total_q        <= '0;
			h_sync_start_q   <= '0;
			h_ext_overflow_q <= '0;
			v_total_q        <= '0;
			v_overflow_q     <= '0;
			v_sync_start_q   <= '0;
			v_ext_overflow_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				owsc_pkg::REG_DESKTOP_FORMAT: desktop_format_q <= cfg_data[1:0];
				owsc_pkg::REG_H_TOTAL:        h_total_q        <= cfg_data;
				owsc_pkg::REG_H_SYNC_START:   h_sync_start_q   <= cfg_data;
				owsc_pkg::REG_H_EXT_OVERFLOW: h_ext_overflow_q <= cfg_data;
				owsc_pkg::REG_V_TOTAL:        v_total_q        <= cfg_data;
				owsc_pkg::REG_V_OVERFLOW:     v_overflow_q     <= cfg_data;
				owsc_pkg::REG_V_SYNC_START:   v_sync_start_q   <= cfg_data;
				owsc_pkg::REG_V_EXT_OVERFLOW: v_ext_overflow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic [NSTG-1:0] valid_s;
	logic [NSTG-1:0] adv;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		adv[NSTG-1] = !valid_s[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !valid_s[k] || adv[k+1];
		end
	end

	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[0]) valid_s[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// ---------------- preparation stage ----------------
	// skews from CRTC timing
	logic [11:0]                  ht, hss;
	logic [10:0]                  vt, vss;
	logic [POS_W-1:0]             xs, ys;
	logic [owsc_pkg::DIFF_W-1:0]  dw, dh;
	logic                         h_div, v_div, fmt_bad;
	logic [7:0]                   r, g, b;
	logic [owsc_pkg::KEY_W-1:0]   kv, km;
	owsc_pkg::side_t              side_d;
	logic [owsc_pkg::REM_W-1:0]   h_rem_d, v_rem_d;

	assign ht  = {h_ext_overflow_q[0], h_total_q, 3'b000};
	assign hss = {h_ext_overflow_q[3], h_sync_start_q, 3'b000};
	assign vt  = {v_ext_overflow_q[7], v_overflow_q[5], v_overflow_q[0], v_total_q};
	assign vss = {v_ext_overflow_q[5], v_overflow_q[7], v_overflow_q[2], v_sync_start_q};

	assign xs = POS_W'(ht) + owsc_pkg::H_TOTAL_ADJ - POS_W'(hss) - owsc_pkg::H_SKEW_ADJ;
	assign ys = POS_W'(vt) + owsc_pkg::V_TOTAL_ADJ - POS_W'(vss) - owsc_pkg::V_SKEW_ADJ;

	// drawn size as signed difference; divide only when source is smaller
	assign dw = {2'b00, dst_right} - {2'b00, dst_left} + owsc_pkg::W_EXTRA;
	assign dh = {2'b00, dst_bottom} - {2'b00, dst_top} + owsc_pkg::H_EXTRA;
	assign h_div = !dw[owsc_pkg::DIFF_W-1] && (dw != '0)
		&& ({2'b00, src_width} < dw[owsc_pkg::DVS_W-1:0]);
	assign v_div = !dh[owsc_pkg::DIFF_W-1] && (dh != '0)
		&& ({2'b00, src_height} < dh[owsc_pkg::DVS_W-1:0]);

	assign h_rem_d = (src_width == '0) ? '0 : owsc_pkg::REM_W'(src_width - 1'b1);
	assign v_rem_d = (src_height == '0) ? '0 : owsc_pkg::REM_W'(src_height - 1'b1);

	assign fmt_bad = (overlay_format != owsc_pkg::OVL_YUV422)
		&& (overlay_format != owsc_pkg::OVL_RGB565);

	// key colour packing
	assign r = key_color[23:16];
	assign g = key_color[15:8];
	assign b = key_color[7:0];

	always_comb begin
		unique case (desktop_format_q)
			owsc_pkg::DESK_PAL8: begin
				kv = key_color;
				km = owsc_pkg::MASK_8;
			end
			owsc_pkg::DESK_RGB555: begin
				kv = {9'd0, r[7:3], g[7:3], b[7:3]};
				km = owsc_pkg::MASK_16;
			end
			owsc_pkg::DESK_RGB565: begin
				kv = {8'd0, r[7:3], g[7:2], b[7:3]};
				km = owsc_pkg::MASK_16;
			end
			default: begin
				kv = key_color;
				km = owsc_pkg::MASK_24;
			end
		endcase
	end

	// results, all zero for an unsupported format
	always_comb begin
		side_d = '0;
		side_d.format_error = 1'b1;
		if (!fmt_bad) begin
			side_d.format_error = 1'b0;
			side_d.rgb_overlay  = (overlay_format == owsc_pkg::OVL_RGB565);
			side_d.key_value    = kv;
			side_d.key_mask     = km;
			side_d.win_x_start  = POS_W'(dst_left) + owsc_pkg::X_START_ADJ + xs;
			side_d.win_x_end    = POS_W'(dst_right) + owsc_pkg::X_END_ADJ + xs;
			side_d.win_y_start  = POS_W'(dst_top) + ys;
			side_d.win_y_end    = POS_W'(dst_bottom) + owsc_pkg::Y_END_ADJ + ys;
			side_d.h_div        = h_div;
			side_d.v_div        = v_div;
		end
	end

	owsc_pkg::side_t              side_s [NSTG-1];
	logic [owsc_pkg::DVS_W-1:0]   h_dvs_s1, v_dvs_s1;
	logic [owsc_pkg::REM_W-1:0]   h_rem_s1, v_rem_s1;

	// divider operands
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			h_dvs_s1  <= dw[owsc_pkg::DVS_W-1:0];
			v_dvs_s1  <= dh[owsc_pkg::DVS_W-1:0];
			h_rem_s1  <= h_rem_d;
			v_rem_s1  <= v_rem_d;
		end
	end

	// ---------------- divider stages ----------------
	logic [owsc_pkg::QUO_W-1:0] h_quo, v_quo;

	owsc_div_pipe #(
		.BITS_PER_STAGE (DIV_BITS_PER_STAGE),
		.STAGES         (DIV_STAGES)
	) u_h_div (
		.clk    (clk),
		.adv    (adv[DIV_STAGES:1]),
		.dvs_in (h_dvs_s1),
		.rem_in (h_rem_s1),
		.quo    (h_quo)
	);

	owsc_div_pipe #(
		.BITS_PER_STAGE (DIV_BITS_PER_STAGE),
		.STAGES         (DIV_STAGES)
	) u_v_div (
		.clk    (clk),
		.adv    (adv[DIV_STAGES:1]),
		.dvs_in (v_dvs_s1),
		.rem_in (v_rem_s1),
		.quo    (v_quo)
	);

	// side data travels in step with the divider
	always_ff @(posedge clk) begin
		if (adv[0]) side_s[0] <= side_d;
		for (int k = 1; k < NSTG - 1; k++) begin
			if (adv[k]) side_s[k] <= side_s[k-1];
		end
	end

	// ---------------- output register ----------------
	owsc_pkg::side_t            side_last;
	logic [owsc_pkg::HZ_W-1:0]  h_zoom_d;
	logic [owsc_pkg::VZ_W-1:0]  v_zoom_d;

	assign side_last = side_s[NSTG-2];

	always_comb begin
		if (side_last.format_error) begin
			h_zoom_d = '0;
			v_zoom_d = '0;
		end else begin
			h_zoom_d = side_last.h_div ? owsc_pkg::HZ_W'(h_quo) : owsc_pkg::H_ZOOM_UNITY;
			v_zoom_d = side_last.v_div ? (owsc_pkg::V_ZOOM_FLAG | owsc_pkg::VZ_W'(v_quo))
				: owsc_pkg::V_ZOOM_UNITY;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			format_error <= side_last.format_error;
			rgb_overlay  <= side_last.rgb_overlay;
			key_value    <= side_last.key_value;
			key_mask     <= side_last.key_mask;
			win_x_start  <= side_last.win_x_start;
			win_x_end    <= side_last.win_x_end;
			win_y_start  <= side_last.win_y_start;
			win_y_end    <= side_last.win_y_end;
			h_zoom       <= h_zoom_d;
			v_zoom       <= v_zoom_d;
		end
	end

	assign out_valid = valid_s[NSTG-1];

endmodule

// File: rtl/owsc_checker.sv
// ----------------------------------------------------------------------------
// owsc_checker
// Port-level checks for the overlay window setup calculator, bound to top.
// ----------------------------------------------------------------------------
`include "overlay_window_setup_calc_top_macros.svh"

module owsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          format_error,
	input logic                          rgb_overlay,
	input logic [owsc_pkg::KEY_W-1:0]    key_value,
	input logic [owsc_pkg::KEY_W-1:0]    key_mask,
	input logic [owsc_pkg::POS_W-1:0]    win_x_start,
	input logic [owsc_pkg::POS_W-1:0]    win_x_end,
	input logic [owsc_pkg::POS_W-1:0]    win_y_start,
	input logic [owsc_pkg::POS_W-1:0]    win_y_end,
	input logic [owsc_pkg::HZ_W-1:0]     h_zoom,
	input logic [owsc_pkg::VZ_W-1:0]     v_zoom
);

	// stalled result is held (key value, x start and v zoom are checked)
	`OWSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(key_value) && $stable(win_x_start) && $stable(v_zoom),
		"result changed while stalled")

	// an unsupported format leaves every other field zero
	`OWSC_ASSERT_NOW(a_err_zero, out_valid && format_error,
		!rgb_overlay && key_value == '0 && key_mask == '0 && win_x_start == '0
		&& win_x_end == '0 && win_y_start == '0 && win_y_end == '0
		&& h_zoom == '0 && v_zoom == '0,
		"error result carries non-zero fields")

	// mask is one of the three compare widths
	`OWSC_ASSERT_NOW(a_mask_legal, out_valid && !format_error,
		key_mask == owsc_pkg::MASK_8 || key_mask == owsc_pkg::MASK_16
		|| key_mask == owsc_pkg::MASK_24,
		"illegal key mask")

	// zoom factors never exceed unity
	`OWSC_ASSERT_NOW(a_zoom_range, out_valid && !format_error,
		h_zoom <= owsc_pkg::H_ZOOM_UNITY && (v_zoom == owsc_pkg::V_ZOOM_UNITY
		|| (v_zoom[14] && v_zoom[13:10] == 4'd0)),
		"zoom factor out of range")

endmodule

bind overlay_window_setup_calc_top owsc_checker u_owsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.format_error (format_error),
	.rgb_overlay  (rgb_overlay),
	.key_value    (key_value),
	.key_mask     (key_mask),
	.win_x_start  (win_x_start),
	.win_x_end    (win_x_end),
	.win_y_start  (win_y_start),
	.win_y_end    (win_y_end),
	.h_zoom       (h_zoom),
	.v_zoom       (v_zoom)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for overlay_window_setup_calc_top. Requests go in over
// the input handshake and a local predictor works out the overlay register
// values for each accepted transfer. Results are checked field by field, in
// order, against the predictions. The CRTC and desktop settings are changed
// between bursts while the pipeline is empty. Both handshakes are throttled
// at random, except in one random pass and the closing back-to-back burst.
// ----------------------------------------------------------------------------
module tb_top;
	import owsc_pkg::*;

	// Overlay formats the block does not support
	localparam logic [FMT_W-1:0] FMT_UNSUP_A = 2'd2;
	localparam logic [FMT_W-1:0] FMT_UNSUP_B = 2'd3;

	localparam int NUM_REGS = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
		REG_DESKTOP_FORMAT, REG_H_TOTAL, REG_H_SYNC_START, REG_H_EXT_OVERFLOW,
		REG_V_TOTAL, REG_V_OVERFLOW, REG_V_SYNC_START, REG_V_EXT_OVERFLOW
	};

	typedef struct packed {
		logic [FMT_W-1:0]   fmt;
		logic [KEY_W-1:0]   key;
		logic [COORD_W-1:0] x_lo;
		logic [COORD_W-1:0] x_hi;
		logic [COORD_W-1:0] y_lo;
		logic [COORD_W-1:0] y_hi;
		logic [SRC_W-1:0]   src_w;
		logic [SRC_W-1:0]   src_h;
	} ovl_request_t;

	typedef struct packed {
		logic             err;
		logic             rgb;
		logic [KEY_W-1:0] key_val;
		logic [KEY_W-1:0] key_msk;
		logic [POS_W-1:0] x_start;
		logic [POS_W-1:0] x_end;
		logic [POS_W-1:0] y_start;
		logic [POS_W-1:0] y_end;
		logic [HZ_W-1:0]  hz;
		logic [VZ_W-1:0]  vz;
	} ovl_regs_t;

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] crtc_setting_t;

	// DUT connections
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [FMT_W-1:0]     overlay_format = '0;
	logic [KEY_W-1:0]     key_color = '0;
	logic [COORD_W-1:0]   dst_left = '0;
	logic [COORD_W-1:0]   dst_right = '0;
	logic [COORD_W-1:0]   dst_top = '0;
	logic [COORD_W-1:0]   dst_bottom = '0;
	logic [SRC_W-1:0]     src_width = '0;
	logic [SRC_W-1:0]     src_height = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 format_error;
	logic                 rgb_overlay;
	logic [KEY_W-1:0]     key_value;
	logic [KEY_W-1:0]     key_mask;
	logic [POS_W-1:0]     win_x_start;
	logic [POS_W-1:0]     win_x_end;
	logic [POS_W-1:0]     win_y_start;
	logic [POS_W-1:0]     win_y_end;
	logic [HZ_W-1:0]      h_zoom;
	logic [VZ_W-1:0]      v_zoom;

	// Shadow of the configuration, expected register values, throttling
	logic [CFG_W-1:0] cfg_shadow [NUM_REGS];
	ovl_regs_t        pending_regs [$];
	int               mismatch_cnt = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               stall_left = 0;

	overlay_window_setup_calc_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.overlay_format (overlay_format),
		.key_color      (key_color),
		.dst_left       (dst_left),
		.dst_right      (dst_right),
		.dst_top        (dst_top),
		.dst_bottom     (dst_bottom),
		.src_width      (src_width),
		.src_height     (src_height),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.format_error   (format_error),
		.rgb_overlay    (rgb_overlay),
		.key_value      (key_value),
		.key_mask       (key_mask),
		.win_x_start    (win_x_start),
		.win_x_end      (win_x_end),
		.win_y_start    (win_y_start),
		.win_y_end      (win_y_end),
		.h_zoom         (h_zoom),
		.v_zoom         (v_zoom)
	);

	always #2 clk = ~clk;

	// Overlay register values for one request under the current shadow setting
	function automatic ovl_regs_t predict_overlay_regs(input ovl_request_t rq);
		ovl_regs_t        res;
		logic [7:0]       red, grn, blu;
		logic [CFG_W-1:0] h_ext, v_ovf, v_ext;
		logic [POS_W-1:0] h_tot, h_sync, x_skew, v_tot, v_sync, y_skew;
		int               drawn_w, drawn_h, num_w, num_h;
		res = '0;
		if (rq.fmt != OVL_YUV422 && rq.fmt != OVL_RGB565) begin
			res.err = 1'b1;
			return res;
		end
		res.rgb = (rq.fmt == OVL_RGB565);

		// key colour packed to the desktop format
		red = rq.key[23:16];
		grn = rq.key[15:8];
		blu = rq.key[7:0];
		case (cfg_shadow[REG_DESKTOP_FORMAT][1:0])
			DESK_PAL8: begin
				res.key_val = rq.key;
				res.key_msk = 24'h0000ff;
			end
			DESK_RGB555: begin
				res.key_val = {9'd0, red[7:3], grn[7:3], blu[7:3]};
				res.key_msk = 24'h00ffff;
			end
			DESK_RGB565: begin
				res.key_val = {8'd0, red[7:3], grn[7:2], blu[7:3]};
				res.key_msk = 24'h00ffff;
			end
			default: begin
				res.key_val = rq.key;
				res.key_msk = 24'hffffff;
			end
		endcase

		// skews from the CRTC bytes, all modulo 2^16
		h_ext  = cfg_shadow[REG_H_EXT_OVERFLOW];
		v_ovf  = cfg_shadow[REG_V_OVERFLOW];
		v_ext  = cfg_shadow[REG_V_EXT_OVERFLOW];
		h_tot  = {4'd0, h_ext[0], cfg_shadow[REG_H_TOTAL], 3'd0} + 16'd40;
		h_sync = {4'd0, h_ext[3], cfg_shadow[REG_H_SYNC_START], 3'd0};
		x_skew = h_tot - h_sync - 16'd24;
		v_tot  = {5'd0, v_ext[7], v_ovf[5], v_ovf[0], cfg_shadow[REG_V_TOTAL]} + 16'd2;
		v_sync = {5'd0, v_ext[5], v_ovf[7], v_ovf[2], cfg_shadow[REG_V_SYNC_START]};
		y_skew = v_tot - v_sync - 16'd7;
		res.x_start = {4'd0, rq.x_lo} + 16'd1 + x_skew;
		res.x_end   = {4'd0, rq.x_hi} + 16'd4 + x_skew;
		res.y_start = {4'd0, rq.y_lo} + y_skew;
		res.y_end   = {4'd0, rq.y_hi} + 16'd5 + y_skew;

		// zoom: divide only when the source is smaller than the drawn size
		drawn_w = int'(rq.x_hi) - int'(rq.x_lo) + 6;
		drawn_h = int'(rq.y_hi) - int'(rq.y_lo) + 2;
		num_w = (rq.src_w == '0) ? 0 : (int'(rq.src_w) - 1) * 1024;
		num_h = (rq.src_h == '0) ? 0 : (int'(rq.src_h) - 1) * 1024;
		if (drawn_w <= 0 || int'(rq.src_w) >= drawn_w)
			res.hz = 14'd1024;
		else
			res.hz = HZ_W'(num_w / drawn_w);
		if (drawn_h <= 0 || int'(rq.src_h) >= drawn_h)
			res.vz = 15'h03ff;
		else
			res.vz = VZ_W'(num_h / drawn_h) | 15'h4000;
		return res;
	endfunction

	function automatic ovl_request_t make_request(input logic [FMT_W-1:0] fmt,
			input logic [KEY_W-1:0] key, input int x0, input int x1, input int y0,
			input int y1, input int sw, input int sh);
		ovl_request_t rq;
		rq.fmt   = fmt;
		rq.key   = key;
		rq.x_lo  = COORD_W'(x0);
		rq.x_hi  = COORD_W'(x1);
		rq.y_lo  = COORD_W'(y0);
		rq.y_hi  = COORD_W'(y1);
		rq.src_w = SRC_W'(sw);
		rq.src_h = SRC_W'(sh);
		return rq;
	endfunction

	// Mostly well-formed requests, with inverted rectangles, odd sizes and
	// unsupported formats mixed in
	function automatic ovl_request_t rand_request();
		ovl_request_t       rq;
		logic [COORD_W-1:0] a, b, c, d;
		int                 span_w, span_h;
		if ($urandom_range(0, 19) == 0)
			rq.fmt = ($urandom_range(0, 1) == 0) ? FMT_UNSUP_A : FMT_UNSUP_B;
		else
			rq.fmt = ($urandom_range(0, 1) == 0) ? OVL_YUV422 : OVL_RGB565;
		rq.key = KEY_W'($urandom);
		a = COORD_W'($urandom);
		b = COORD_W'($urandom);
		c = COORD_W'($urandom);
		d = COORD_W'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				// any order, often inverted
			end
			1, 2: begin
				// narrow window, may wrap into an inverted one
				b = a + COORD_W'($urandom_range(0, 63));
				d = c + COORD_W'($urandom_range(0, 63));
			end
			default: begin
				if (a > b) {a, b} = {b, a};
				if (c > d) {c, d} = {d, c};
			end
		endcase
		rq.x_lo = a;
		rq.x_hi = b;
		rq.y_lo = c;
		rq.y_hi = d;
		span_w = int'(b) - int'(a) + 6;
		span_h = int'(d) - int'(c) + 2;
		case ($urandom_range(0, 9))
			0: begin
				rq.src_w = SRC_W'($urandom);
				rq.src_h = SRC_W'($urandom);
			end
			1: begin
				// around the drawn size, where the zoom switches to division
				rq.src_w = (span_w > 1 && span_w < 2047) ?
					SRC_W'(span_w - 1 + int'($urandom_range(0, 2))) :
					SRC_W'($urandom_range(1, 1024));
				rq.src_h = (span_h > 1 && span_h < 2047) ?
					SRC_W'(span_h - 1 + int'($urandom_range(0, 2))) :
					SRC_W'($urandom_range(1, 1024));
			end
			2, 3: begin
				rq.src_w = SRC_W'($urandom_range(1, 32));
				rq.src_h = SRC_W'($urandom_range(1, 32));
			end
			default: begin
				rq.src_w = SRC_W'($urandom_range(1, 1024));
				rq.src_h = SRC_W'($urandom_range(1, 1024));
			end
		endcase
		return rq;
	endfunction

	function automatic logic [CFG_W-1:0] rand_byte();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic crtc_setting_t rand_setting();
		crtc_setting_t s;
		for (int i = 0; i < NUM_REGS; i++)
			s[i] = rand_byte();
		return s;
	endfunction

	// Write every register in turn; only called with the pipeline empty
	task automatic apply_setting(input crtc_setting_t s);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= s[REG_ORDER[i]];
			do @(posedge clk); while (!cfg_ready);
			cfg_shadow[REG_ORDER[i]] = s[REG_ORDER[i]];
		end
		cfg_valid <= 1'b0;
	endtask

	// One request transfer; valid stays high unless an idle burst follows
	task automatic send_request(input ovl_request_t rq);
		in_valid       <= 1'b1;
		overlay_format <= rq.fmt;
		key_color      <= rq.key;
		dst_left       <= rq.x_lo;
		dst_right      <= rq.x_hi;
		dst_top        <= rq.y_lo;
		dst_bottom     <= rq.y_hi;
		src_width      <= rq.src_w;
		src_height     <= rq.src_h;
		do @(posedge clk); while (!in_ready);
		pending_regs.push_back(predict_overlay_regs(rq));
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_regs.size() != 0)
			@(posedge clk);
	endtask

	// Every desktop format, both overlay formats, the unsupported ones
	task automatic test_key_packing();
		crtc_setting_t s;
		gap_pct   = 30;
		stall_pct = 30;
		for (int f = 0; f < 4; f++) begin
			s = '0;
			s[REG_DESKTOP_FORMAT] = CFG_W'(f);
			apply_setting(s);
			send_request(make_request(OVL_YUV422, 24'hffffff, 100, 419, 50, 289, 160, 120));
			send_request(make_request(OVL_RGB565, 24'h5a3c81, 100, 419, 50, 289, 160, 120));
			drain_pipeline();
		end
		send_request(make_request(FMT_UNSUP_A, 24'hffffff, 4095, 0, 4095, 0, 2047, 2047));
		send_request(make_request(FMT_UNSUP_B, 24'h123456, 10, 900, 10, 700, 5, 5));
		drain_pipeline();
	endtask

	// Skew extremes, window wrap, inverted rectangles and zoom boundaries
	task automatic test_window_geometry();
		crtc_setting_t s;
		gap_pct   = 20;
		stall_pct = 20;
		// largest totals, zero sync starts
		s = '0;
		s[REG_DESKTOP_FORMAT] = CFG_W'(DESK_TRUE);
		s[REG_H_TOTAL]        = 8'hff;
		s[REG_H_EXT_OVERFLOW] = 8'h01;
		s[REG_V_TOTAL]        = 8'hff;
		s[REG_V_OVERFLOW]     = 8'h21;
		s[REG_V_EXT_OVERFLOW] = 8'h80;
		apply_setting(s);
		send_request(make_request(OVL_YUV422, 24'h000000, 4095, 4095, 4095, 4095, 1024, 1024));
		send_request(make_request(OVL_RGB565, 24'h000000, 0, 0, 0, 0, 1, 1));
		send_request(make_request(OVL_YUV422, 24'hffffff, 0, 4095, 0, 4095, 1024, 1024));
		send_request(make_request(OVL_RGB565, 24'h800001, 0, 4095, 0, 4095, 2047, 2047));
		send_request(make_request(OVL_YUV422, 24'h7ffffe, 0, 4095, 0, 4095, 0, 0));
		drain_pipeline();
		// zero totals, largest sync starts: both skews wrap below zero
		s = '0;
		s[REG_DESKTOP_FORMAT] = CFG_W'(DESK_RGB565);
		s[REG_H_SYNC_START]   = 8'hff;
		s[REG_H_EXT_OVERFLOW] = 8'h08;
		s[REG_V_SYNC_START]   = 8'hff;
		s[REG_V_OVERFLOW]     = 8'h84;
		s[REG_V_EXT_OVERFLOW] = 8'h20;
		apply_setting(s);
		send_request(make_request(OVL_YUV422, 24'h0f0f0f, 4000, 10, 3000, 5, 3, 3));
		send_request(make_request(OVL_RGB565, 24'hf0f0f0, 500, 494, 700, 698, 1, 1));
		send_request(make_request(OVL_YUV422, 24'haaaaaa, 500, 495, 700, 699, 0, 0));
		send_request(make_request(OVL_RGB565, 24'h555555, 10, 13, 20, 27, 9, 8));
		send_request(make_request(OVL_YUV422, 24'hc3c3c3, 0, 0, 4095, 4095, 5, 1));
		drain_pipeline();
	endtask

	// Random settings and requests, with varying amounts of throttling
	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			apply_setting(rand_setting());
			gap_pct   = (p == 2) ? 0 : 10 * int'($urandom_range(0, 6));
			stall_pct = (p == 2) ? 0 : 10 * int'($urandom_range(0, 6));
			repeat (250) send_request(rand_request());
			drain_pipeline();
		end
	endtask

	// Closing burst at full rate on both sides
	task automatic test_back_to_back();
		apply_setting(rand_setting());
		gap_pct   = 0;
		stall_pct = 0;
		repeat (150) send_request(rand_request());
		drain_pipeline();
	endtask

	task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Result side throttling: random stall bursts, none when off
	always @(posedge clk) begin
		if (stall_pct == 0) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		ovl_regs_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_regs.size() == 0) begin
				$display("%0t: result with none expected, expected nothing actual x_start %h",
					$time, win_x_start);
				mismatch_cnt++;
			end else begin
				want = pending_regs.pop_front();
				compare_field("format_error", want.err, format_error);
				compare_field("rgb_overlay", want.rgb, rgb_overlay);
				compare_field("key_value", want.key_val, key_value);
				compare_field("key_mask", want.key_msk, key_mask);
				compare_field("win_x_start", want.x_start, win_x_start);
				compare_field("win_x_end", want.x_end, win_x_end);
				compare_field("win_y_start", want.y_start, win_y_start);
				compare_field("win_y_end", want.y_end, win_y_end);
				compare_field("h_zoom", want.hz, h_zoom);
				compare_field("v_zoom", want.vz, v_zoom);
			end
		end
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Test sequence
	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			cfg_shadow[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_packing();
		test_window_geometry();
		test_random_traffic();
		test_back_to_back();
		// let anything stray leave the pipeline before the verdict
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0 && pending_regs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
